### src/fxalu_pkg.sv
package fxalu_pkg;

   localparam int WORD_W        = 32;
   localparam int FRAC_BITS_DEF = 8;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_GE       = 4'd6,
      OP_LE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_INC      = 4'd10,
      OP_DEC      = 4'd11,
      OP_MIN      = 4'd12,
      OP_MAX      = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT   = 4'd15
   } op_type;

   // per-beat control and finished result carried down the divider row
   typedef struct packed {
      logic              valid;
      logic              is_div;
      logic              neg;
      logic              flag;
      logic              err;
      logic [WORD_W-1:0] val;
   } ctl_type;

endpackage

### src/fxalu_front.sv
module fxalu_front
   import fxalu_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int DW = WORD_W + FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic [3:0]               opcode,
   input  logic signed [WORD_W-1:0] operand_a,
   input  logic signed [WORD_W-1:0] operand_b,
   output ctl_type                  dn_ctl,
   output logic [WORD_W-1:0]        dn_rem,
   output logic [DW-1:0]            dn_dq,
   output logic [WORD_W-1:0]        dn_dvs
);

   localparam logic [63:0] MASK64 = (64'd1 << FRAC_BITS) - 64'd1;
   localparam logic [32:0] MASK33 = (33'd1 << FRAC_BITS) - 33'd1;

   // stage a: operands and product
   logic                     vld_a_ff, vld_a_in;
   logic [3:0]               op_a_ff, op_a_in;
   logic signed [WORD_W-1:0] a_ff, a_in;
   logic signed [WORD_W-1:0] b_ff, b_in;
   logic signed [63:0]       prod_ff, prod_in;

   // stage b: simple results and divider setup
   ctl_type                  ctl_ff, ctl_in;
   logic [DW-1:0]            dq_ff, dq_in;
   logic [WORD_W-1:0]        dvs_ff, dvs_in;

   logic signed [63:0]       mul_adj;
   logic signed [32:0]       ti_adj;
   logic signed [32:0]       ti_shr;
   logic [WORD_W-1:0]        abs_a;
   logic [WORD_W-1:0]        abs_b;

   assign vld_a_in = take;
   assign op_a_in  = opcode;
   assign a_in     = operand_a;
   assign b_in     = operand_b;
   assign prod_in  = 64'(operand_a) * 64'(operand_b);

   assign mul_adj = prod_ff + (prod_ff[63] ? $signed(MASK64) : 64'sd0);
   assign ti_adj  = $signed({a_ff[WORD_W-1], a_ff}) + (a_ff[WORD_W-1] ? $signed(MASK33) : 33'sd0);
   assign ti_shr  = ti_adj >>> FRAC_BITS;
   assign abs_a   = a_ff[WORD_W-1] ? WORD_W'(-a_ff) : WORD_W'(a_ff);
   assign abs_b   = b_ff[WORD_W-1] ? WORD_W'(-b_ff) : WORD_W'(b_ff);

   always_comb begin
      ctl_in        = '0;
      ctl_in.valid  = vld_a_ff;
      ctl_in.neg    = a_ff[WORD_W-1] ^ b_ff[WORD_W-1];
      case (op_type'(op_a_ff))
         OP_ADD:      ctl_in.val = a_ff + b_ff;
         OP_SUB:      ctl_in.val = a_ff - b_ff;
         OP_MUL:      ctl_in.val = mul_adj[FRAC_BITS +: WORD_W];
         OP_DIV: begin
            ctl_in.is_div = 1'b1;
            ctl_in.err    = (b_ff == '0);
         end
         OP_GT:       ctl_in.flag = (a_ff > b_ff);
         OP_LT:       ctl_in.flag = (a_ff < b_ff);
         OP_GE:       ctl_in.flag = (a_ff >= b_ff);
         OP_LE:       ctl_in.flag = (a_ff <= b_ff);
         OP_EQ:       ctl_in.flag = (a_ff == b_ff);
         OP_NE:       ctl_in.flag = (a_ff != b_ff);
         OP_INC:      ctl_in.val = a_ff + 32'sd1;
         OP_DEC:      ctl_in.val = a_ff - 32'sd1;
         OP_MIN:      ctl_in.val = (a_ff > b_ff) ? b_ff : a_ff;
         OP_MAX:      ctl_in.val = (a_ff < b_ff) ? b_ff : a_ff;
         OP_FROM_INT: ctl_in.val = a_ff << FRAC_BITS;
         OP_TO_INT:   ctl_in.val = ti_shr[WORD_W-1:0];
         default:     ctl_in.val = '0;
      endcase
   end

   assign dq_in  = DW'(abs_a) << FRAC_BITS;
   assign dvs_in = abs_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff     <= 1'b0;
         ctl_ff.valid <= 1'b0;
      end else begin
         vld_a_ff     <= vld_a_in;
         ctl_ff.valid <= ctl_in.valid;
      end
      op_a_ff       <= op_a_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      prod_ff       <= prod_in;
      ctl_ff.is_div <= ctl_in.is_div;
      ctl_ff.neg    <= ctl_in.neg;
      ctl_ff.flag   <= ctl_in.flag;
      ctl_ff.err    <= ctl_in.err;
      ctl_ff.val    <= ctl_in.val;
      dq_ff         <= dq_in;
      dvs_ff        <= dvs_in;
   end

   assign dn_ctl = ctl_ff;
   assign dn_rem = '0;
   assign dn_dq  = dq_ff;
   assign dn_dvs = dvs_ff;

endmodule

### src/fxalu_div_cell.sv
module fxalu_div_cell
   import fxalu_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int DW = WORD_W + FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  ctl_type           up_ctl,
   input  logic [WORD_W-1:0] up_rem,
   input  logic [DW-1:0]     up_dq,
   input  logic [WORD_W-1:0] up_dvs,
   output ctl_type           dn_ctl,
   output logic [WORD_W-1:0] dn_rem,
   output logic [DW-1:0]     dn_dq,
   output logic [WORD_W-1:0] dn_dvs
);

   ctl_type           ctl_ff;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [DW-1:0]     dq_ff, dq_in;
   logic [WORD_W-1:0] dvs_ff;

   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   diff;
   logic              fits;

   // one restoring step: shift in the next dividend bit, subtract when it fits
   assign trial  = {up_rem, up_dq[DW-1]};
   assign diff   = trial - {1'b0, up_dvs};
   assign fits   = (trial >= {1'b0, up_dvs});
   assign rem_in = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
   assign dq_in  = {up_dq[DW-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= up_ctl.valid;
      end
      ctl_ff.is_div <= up_ctl.is_div;
      ctl_ff.neg    <= up_ctl.neg;
      ctl_ff.flag   <= up_ctl.flag;
      ctl_ff.err    <= up_ctl.err;
      ctl_ff.val    <= up_ctl.val;
      rem_ff        <= rem_in;
      dq_ff         <= dq_in;
      dvs_ff        <= up_dvs;
   end

   assign dn_ctl = ctl_ff;
   assign dn_rem = rem_ff;
   assign dn_dq  = dq_ff;
   assign dn_dvs = dvs_ff;

   property p_rem_below_divisor;
      @(posedge clock) disable iff (reset)
         (ctl_ff.valid && ctl_ff.is_div && !ctl_ff.err) |-> (rem_ff < dvs_ff);
   endproperty
   a_rem_below_divisor: assert property (p_rem_below_divisor)
      else $error("partial remainder not below divisor");

   property p_div_err_zero_divisor;
      @(posedge clock) disable iff (reset)
         (ctl_ff.valid && ctl_ff.is_div) |-> (ctl_ff.err == (dvs_ff == '0));
   endproperty
   a_div_err_zero_divisor: assert property (p_div_err_zero_divisor)
      else $error("divide error flag disagrees with divisor");

endmodule

### src/fixed_point_alu.sv
// channel   ports                                          direction  handshake
// request   req_opcode, req_operand_a, req_operand_b       in         start & !busy
// response  rsp_result_value, rsp_compare_flag,
//           rsp_divide_error                               out        rsp_valid strobe
//
// rsp_valid rises after the accepting edge through FRAC_BITS + 35
// register stages: two front stages, FRAC_BITS + 32 one-bit divider cells, one output stage
// beats are accepted every cycle unless busy; all opcodes run the same row so order is kept
// reset is synchronous; busy is high for the cycle after reset and low afterwards
// the receiver cannot stall, each result is shown for exactly one cycle
module fixed_point_alu
   import fxalu_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [3:0]               req_opcode,
   input  logic signed [WORD_W-1:0] req_operand_a,
   input  logic signed [WORD_W-1:0] req_operand_b,
   output logic                     rsp_valid,
   output logic signed [WORD_W-1:0] rsp_result_value,
   output logic                     rsp_compare_flag,
   output logic                     rsp_divide_error
);

   localparam int DW = WORD_W + FRAC_BITS;

   logic                     busy_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] rsp_val_ff, rsp_val_in;
   logic                     rsp_flag_ff, rsp_flag_in;
   logic                     rsp_err_ff, rsp_err_in;

   ctl_type                  ctl_chain [0:DW];
   logic [WORD_W-1:0]        rem_chain [0:DW];
   logic [DW-1:0]            dq_chain  [0:DW];
   logic [WORD_W-1:0]        dvs_chain [0:DW];

   ctl_type                  last_ctl;
   logic [WORD_W-1:0]        quo;
   logic [WORD_W-1:0]        quo_signed;

   fxalu_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (start && !busy_ff),
      .opcode    (req_opcode),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .dn_ctl    (ctl_chain[0]),
      .dn_rem    (rem_chain[0]),
      .dn_dq     (dq_chain[0]),
      .dn_dvs    (dvs_chain[0])
   );

   for (genvar i = 0; i < DW; i++) begin : g_cell
      fxalu_div_cell #(
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .up_ctl (ctl_chain[i]),
         .up_rem (rem_chain[i]),
         .up_dq  (dq_chain[i]),
         .up_dvs (dvs_chain[i]),
         .dn_ctl (ctl_chain[i+1]),
         .dn_rem (rem_chain[i+1]),
         .dn_dq  (dq_chain[i+1]),
         .dn_dvs (dvs_chain[i+1])
      );
   end

   assign last_ctl   = ctl_chain[DW];
   assign quo        = dq_chain[DW][WORD_W-1:0];
   assign quo_signed = last_ctl.neg ? WORD_W'(-quo) : quo;

   assign rsp_valid_in = last_ctl.valid;
   assign rsp_flag_in  = last_ctl.flag;
   assign rsp_err_in   = last_ctl.err;
   assign rsp_val_in   = (last_ctl.is_div && !last_ctl.err) ? $signed(quo_signed)
                       : (last_ctl.is_div ? '0 : $signed(last_ctl.val));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_val_ff  <= rsp_val_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_val_ff;
   assign rsp_compare_flag = rsp_flag_ff;
   assign rsp_divide_error = rsp_err_ff;

   property p_err_gives_zero;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_divide_error) |-> (rsp_result_value == '0);
   endproperty
   a_err_gives_zero: assert property (p_err_gives_zero)
      else $error("divide error with nonzero result");

   property p_flag_err_exclusive;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> !(rsp_compare_flag && rsp_divide_error);
   endproperty
   a_flag_err_exclusive: assert property (p_flag_err_exclusive)
      else $error("compare flag and divide error both set");

endmodule
